// File: rtl/cpfd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the packet file deframer.
// Used by the deframer core, the top level and the port checker.
// No dependencies.
package cpfd_pkg;

  // Field widths
  localparam int LEN_W           = 24;
  localparam int WORD_W          = 32;
  localparam int KIND_W          = 2;
  localparam int DEF_LENGTH_BITS = 24;

  // Packed result bus: start, total, type, stored, computed, mismatch, zero pad
  localparam int OUT_FIELDS_W = LEN_W + LEN_W + 3 * WORD_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Framing constants
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam int unsigned MIN_FILE     = 36;
  localparam int unsigned HEADER_LEN   = 32;
  localparam int unsigned PKT_OVERHEAD = 10;
  localparam int unsigned CRC_BYTES    = 4;

  // Record kinds
  localparam logic [KIND_W-1:0] KIND_HEADER    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PACKET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECKED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNCHECKED = 2'd3;

  // One input item as seen by the core
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } step_t;

  // One result record
  typedef struct packed {
    logic [KIND_W-1:0] record_kind;
    logic [LEN_W-1:0]  start_offset;
    logic [LEN_W-1:0]  total_length;
    logic [WORD_W-1:0] packet_type;
    logic [WORD_W-1:0] stored_crc;
    logic [WORD_W-1:0] computed_crc;
    logic              crc_mismatch;
  } rec_t;

  // Reflected CRC-32, one byte folded in
  function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/crc32_packet_file_deframer_unit.sv
// Top level of the CRC-32 packet file deframer: input stage, length register,
// parse core and result register. Depends on cpfd_pkg and cpfd_core.
//
// The block takes a file one byte per item on the s_ stream and reports header,
// packet and trailer records on the m_ stream. It sustains one byte per clock
// while records are taken. A byte that completes a record passes the input
// register, then the parse step with up to two byte-wide CRC-32 updates, and the
// record lands in the result register, which drives m_tvalid. While a record
// waits on m_tready the parse step holds: the input register takes at most one
// more byte and then s_tready drops until the record is taken.
// Set file_length through the cfg channel while no byte is in flight; s_tuser
// marks the first byte of a file and restarts parsing at offset 0.
module crc32_packet_file_deframer_unit
  import cpfd_pkg::*;
#(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // Length register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data,     // file_length
  // Byte input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,      // data_byte
  input  logic [0:0]            s_tuser,      // file_start
  // Record output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,      // start_offset, total_length, packet_type,
                                              // stored_crc, computed_crc, crc_mismatch, pad
  output logic [KIND_W-1:0]     m_tuser       // record_kind
);

  logic [LEN_W-1:0] file_length;
  logic             in_vld;
  step_t            in_item;
  logic             advance;
  logic             rec_valid;
  rec_t             rec;

  // Length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_valid) begin
      file_length <= cfg_data;
    end
  end

  // Core steps when a byte is held and the result slot is free or being taken
  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.data_byte  <= s_tdata;
      in_item.file_start <= s_tuser[0];
    end
  end

  cpfd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .step       (in_item),
    .file_length(file_length),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= rec_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rec_valid) begin
      m_tuser <= rec.record_kind;
      m_tdata <= OUT_DATA_W'({rec.crc_mismatch, rec.computed_crc, rec.stored_crc,
                              rec.packet_type, rec.total_length, rec.start_offset});
    end
  end

endmodule

// File: rtl/cpfd_core.sv
// Parse state and per-byte step logic of the packet file deframer.
// Holds position, phase, CRC registers; emits at most one record per byte.
// Depends on cpfd_pkg.
module cpfd_core
  import cpfd_pkg::*;
#(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  step_t            step,
  input  logic [LEN_W-1:0] file_length,
  output logic             rec_valid,
  output rec_t             rec
);

  // Compare width: covers position, length and start + overhead + payload
  localparam int CW = ((LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W) + 2;

  // Phase codes
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_HEAD    = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC     = 3'd3;
  localparam logic [2:0] PH_TRAIL   = 3'd4;
  localparam logic [2:0] PH_LIMIT   = 3'd5;

  localparam logic [CW-1:0] HEAD_LIMIT = CW'(PKT_OVERHEAD + CRC_BYTES);

  // State registers
  logic [LENGTH_BITS-1:0] byte_position, byte_position_next;
  logic [2:0]             parse_phase, parse_phase_next;
  logic [LENGTH_BITS-1:0] record_start, record_start_next;
  logic [2:0]             bytes_in_record, bytes_in_record_next;
  logic [WORD_W-1:0]      type_word, type_word_next;
  logic [15:0]            payload_count, payload_count_next;
  logic [WORD_W-1:0]      packet_crc, packet_crc_next;
  logic [WORD_W-1:0]      file_crc, file_crc_next;
  logic [WORD_W-1:0]      file_crc_at_boundary, file_crc_at_boundary_next;
  logic [WORD_W-1:0]      crc_shift_in, crc_shift_in_next;

  // Current values, after an optional restart
  logic [LENGTH_BITS-1:0] c_pos, c_rs;
  logic [2:0]             c_phase, c_bir;
  logic [WORD_W-1:0]      c_type, c_pcrc, c_fcrc, c_bound, c_shift;
  logic [15:0]            c_pcount;

  logic [CW-1:0]          pos_x, len_x, tlen, pkt_total;
  logic                   skip, bir0;
  logic [2:0]             bir_inc;
  logic [WORD_W-1:0]      shift_new, pcrc_base;
  logic [LENGTH_BITS-1:0] rs_eff;
  logic [15:0]            plen;
  logic [15:0]            pcount_dec;

  // Restart clears everything but the length register
  always_comb begin
    if (step.file_start) begin
      c_pos    = '0;
      c_phase  = PH_HEADER;
      c_rs     = '0;
      c_bir    = '0;
      c_type   = '0;
      c_pcount = '0;
      c_pcrc   = CRC_ONES;
      c_fcrc   = CRC_ONES;
      c_bound  = CRC_ONES;
      c_shift  = '0;
    end else begin
      c_pos    = byte_position;
      c_phase  = parse_phase;
      c_rs     = record_start;
      c_bir    = bytes_in_record;
      c_type   = type_word;
      c_pcount = payload_count;
      c_pcrc   = packet_crc;
      c_fcrc   = file_crc;
      c_bound  = file_crc_at_boundary;
      c_shift  = crc_shift_in;
    end
  end

  // Shared terms of the step
  assign pos_x      = CW'(c_pos);
  assign len_x      = CW'(file_length);
  assign skip       = (file_length < LEN_W'(MIN_FILE)) || (pos_x >= len_x) ||
                      (c_phase >= PH_LIMIT);
  assign shift_new  = {c_shift[WORD_W-9:0], step.data_byte};
  assign bir0       = (c_bir == 3'd0);
  assign bir_inc    = c_bir + 3'd1;
  assign rs_eff     = bir0 ? c_pos : c_rs;
  assign pcrc_base  = bir0 ? CRC_ONES : c_pcrc;
  assign plen       = shift_new[15:0];
  assign pcount_dec = c_pcount - 16'd1;
  assign pkt_total  = pos_x - CW'(c_rs) + CW'(1);
  assign tlen       = len_x - CW'(record_start_next);

  // Per-byte parse step
  always_comb begin
    byte_position_next        = c_pos;
    parse_phase_next          = c_phase;
    record_start_next         = c_rs;
    bytes_in_record_next      = c_bir;
    type_word_next            = c_type;
    payload_count_next        = c_pcount;
    packet_crc_next           = c_pcrc;
    file_crc_next             = c_fcrc;
    file_crc_at_boundary_next = c_bound;
    crc_shift_in_next         = c_shift;
    rec_valid                 = 1'b0;
    rec                       = '0;

    if (!skip) begin
      file_crc_next      = crc32_byte(c_fcrc, step.data_byte);
      crc_shift_in_next  = shift_new;
      byte_position_next = c_pos + LENGTH_BITS'(1);

      case (c_phase)
        PH_HEADER: begin
          if (pos_x == CW'(HEADER_LEN - 1)) begin
            parse_phase_next     = PH_HEAD;
            bytes_in_record_next = '0;
            rec_valid            = 1'b1;
            rec.record_kind      = KIND_HEADER;
            rec.total_length     = LEN_W'(HEADER_LEN);
          end
        end
        PH_HEAD: begin
          if (bir0) begin
            record_start_next         = c_pos;
            file_crc_at_boundary_next = c_fcrc;
            packet_crc_next           = CRC_ONES;
          end
          if (bir0 && (pos_x + HEAD_LIMIT > len_x)) begin
            // Not even an empty packet fits: rest of file is trailer
            parse_phase_next = PH_TRAIL;
          end else begin
            packet_crc_next      = crc32_byte(pcrc_base, step.data_byte);
            bytes_in_record_next = bir_inc;
            if (bir_inc == 3'd4) begin
              type_word_next = shift_new;
            end
            if (bir_inc == 3'd6) begin
              if (CW'(rs_eff) + HEAD_LIMIT + CW'(plen) > len_x) begin
                parse_phase_next = PH_TRAIL;
              end else begin
                payload_count_next   = plen;
                bytes_in_record_next = '0;
                parse_phase_next     = (plen != 16'd0) ? PH_PAYLOAD : PH_CRC;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          packet_crc_next    = crc32_byte(c_pcrc, step.data_byte);
          payload_count_next = pcount_dec;
          if (pcount_dec == 16'd0) begin
            bytes_in_record_next = '0;
            parse_phase_next     = PH_CRC;
          end
        end
        PH_CRC: begin
          bytes_in_record_next = bir_inc;
          if (bir_inc == 3'd4) begin
            rec_valid            = 1'b1;
            rec.record_kind      = KIND_PACKET;
            rec.start_offset     = LEN_W'(c_rs);
            rec.total_length     = pkt_total[LEN_W-1:0];
            rec.packet_type      = c_type;
            rec.stored_crc       = shift_new;
            rec.computed_crc     = ~c_pcrc;
            rec.crc_mismatch     = (shift_new != ~c_pcrc);
            parse_phase_next     = PH_HEAD;
            bytes_in_record_next = '0;
          end
        end
        default: begin
        end
      endcase

      // Trailer goes out on the last byte of the file
      if (!rec_valid && (parse_phase_next == PH_TRAIL) && (pos_x + CW'(1) == len_x)) begin
        rec_valid        = 1'b1;
        rec.start_offset = LEN_W'(record_start_next);
        rec.total_length = tlen[LEN_W-1:0];
        if (tlen == CW'(CRC_BYTES)) begin
          rec.record_kind  = KIND_CHECKED;
          rec.stored_crc   = shift_new;
          rec.computed_crc = ~file_crc_at_boundary_next;
          rec.crc_mismatch = (shift_new != ~file_crc_at_boundary_next);
        end else begin
          rec.record_kind = KIND_UNCHECKED;
        end
      end
    end
  end

  // State update, one byte per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      parse_phase          <= PH_HEADER;
      record_start         <= '0;
      bytes_in_record      <= '0;
      type_word            <= '0;
      payload_count        <= '0;
      packet_crc           <= CRC_ONES;
      file_crc             <= CRC_ONES;
      file_crc_at_boundary <= CRC_ONES;
      crc_shift_in         <= '0;
    end else if (step_en) begin
      byte_position        <= byte_position_next;
      parse_phase          <= parse_phase_next;
      record_start         <= record_start_next;
      bytes_in_record      <= bytes_in_record_next;
      type_word            <= type_word_next;
      payload_count        <= payload_count_next;
      packet_crc           <= packet_crc_next;
      file_crc             <= file_crc_next;
      file_crc_at_boundary <= file_crc_at_boundary_next;
      crc_shift_in         <= crc_shift_in_next;
    end
  end

endmodule

// File: rtl/cpfd_checker.sv
// Port-level checks for the packet file deframer, bound to the top level.
// Depends on cpfd_pkg and crc32_packet_file_deframer_unit.
module cpfd_checker
  import cpfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]     m_tuser
);

  logic [LEN_W-1:0]  start_offset, total_length;
  logic [WORD_W-1:0] packet_type, stored_crc, computed_crc;
  logic              crc_mismatch;

  assign start_offset = m_tdata[23:0];
  assign total_length = m_tdata[47:24];
  assign packet_type  = m_tdata[79:48];
  assign stored_crc   = m_tdata[111:80];
  assign computed_crc = m_tdata[143:112];
  assign crc_mismatch = m_tdata[144];

  // A stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("record changed while stalled");

  // Header record is fixed at offset zero, 32 bytes, no CRC fields
  a_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HEADER) |->
      (start_offset == '0) && (total_length == LEN_W'(HEADER_LEN)) &&
      (packet_type == '0) && (stored_crc == '0) && !crc_mismatch)
    else $error("bad header record");

  // Checked records flag exactly the CRC disagreement
  a_mismatch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == KIND_PACKET) || (m_tuser == KIND_CHECKED)) |->
      crc_mismatch == (stored_crc != computed_crc))
    else $error("mismatch flag disagrees with CRC words");

  // Trailers carry no type; an unchecked one carries no CRC words
  a_trailer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_UNCHECKED) |->
      (packet_type == '0) && (stored_crc == '0) && (computed_crc == '0) && !crc_mismatch)
    else $error("unchecked trailer with CRC fields");

endmodule

bind crc32_packet_file_deframer_unit cpfd_checker u_cpfd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
